@@ sv/tbsq_pkg.sv @@
// tbsq_pkg: shared types, constants and helpers of the token bucket shaper queue
`timescale 1ns / 1ps

package tbsq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int TAG_BITS    = 16;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = 7;
	localparam int TOK_W       = 16;
	localparam int TMR_W       = 32;
	localparam int KIND_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_MAX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TIME   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT   = 2'd3;

	// reset values of the registers
	localparam logic [TOK_W-1:0] TOKEN_MAX_RST      = 16'd8;
	localparam logic [TMR_W-1:0] TOKEN_INTERVAL_RST = 32'd100;
	localparam logic [TMR_W-1:0] SERVICE_TIME_RST   = 32'd10;
	localparam logic [CNT_W-1:0] BUFFER_LIMIT_RST   = 7'd64;

	// request operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_ARRIVAL = 1'b1;

	// event codes
	localparam logic [KIND_W-1:0] EV_NONE       = 3'd0;
	localparam logic [KIND_W-1:0] EV_DEPARTED   = 3'd1;
	localparam logic [KIND_W-1:0] EV_STARTED    = 3'd2;
	localparam logic [KIND_W-1:0] EV_QUEUED     = 3'd3;
	localparam logic [KIND_W-1:0] EV_DROP_FULL  = 3'd4;
	localparam logic [KIND_W-1:0] EV_DROP_TOKEN = 3'd5;

	typedef enum logic {
		PH_IDLE,
		PH_EXEC
	} tbsq_phase_t;

	typedef struct packed {
		logic [TOK_W-1:0] token_max;
		logic [TMR_W-1:0] token_interval;
		logic [TMR_W-1:0] service_time;
		logic [CNT_W-1:0] buffer_limit;
	} tbsq_cfg_t;

	typedef struct packed {
		logic [TOK_W-1:0]    token_count;
		logic [TMR_W-1:0]    refill_timer;
		logic [TMR_W-1:0]    service_timer;
		logic                busy;
		logic [TAG_BITS-1:0] serving_tag;
		logic [QPTR_W-1:0]   head;
		logic [QPTR_W-1:0]   tail;
		logic [CNT_W-1:0]    count;
	} tbsq_ctx_t;

	typedef struct packed {
		logic [KIND_W-1:0]   event_kind;
		logic [TAG_BITS-1:0] event_tag;
		logic [CNT_W-1:0]    queue_length;
		logic                server_busy;
		logic [TOK_W-1:0]    tokens_left;
	} tbsq_result_t;

	typedef struct packed {
		logic                wr_en;
		logic [QPTR_W-1:0]   wr_addr;
		logic [TAG_BITS-1:0] wr_data;
	} tbsq_mem_wr_t;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

@@ sv/tbsq_if.sv @@
// tbsq_if: valid/ready channels for requests and results
`timescale 1ns / 1ps

interface tbsq_item_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [tbsq_pkg::TAG_BITS-1:0] packet_tag;

	modport source (output valid, output operation, output packet_tag, input ready);
	modport sink (input valid, input operation, input packet_tag, output ready);
endinterface

interface tbsq_result_if;
	logic                          valid;
	logic                          ready;
	logic [tbsq_pkg::KIND_W-1:0]   event_kind;
	logic [tbsq_pkg::TAG_BITS-1:0] event_tag;
	logic [tbsq_pkg::CNT_W-1:0]    queue_length;
	logic                          server_busy;
	logic [tbsq_pkg::TOK_W-1:0]    tokens_left;

	modport source (output valid, output event_kind, output event_tag, output queue_length,
		output server_busy, output tokens_left, input ready);
	modport sink (input valid, input event_kind, input event_tag, input queue_length,
		input server_busy, input tokens_left, output ready);
endinterface

@@ sv/tbsq_step.sv @@
// tbsq_step: next shaper state and result of one request
`timescale 1ns / 1ps

module tbsq_step (
	input  tbsq_pkg::tbsq_cfg_t           cfg,
	input  tbsq_pkg::tbsq_ctx_t           cur,
	input  logic                          operation,
	input  logic [tbsq_pkg::TAG_BITS-1:0] packet_tag,
	input  logic [tbsq_pkg::TAG_BITS-1:0] head_data,
	output tbsq_pkg::tbsq_ctx_t           nxt,
	output tbsq_pkg::tbsq_result_t        res,
	output tbsq_pkg::tbsq_mem_wr_t        mem_wr
);

	logic [tbsq_pkg::TMR_W-1:0] refill_inc;
	logic [tbsq_pkg::CNT_W-1:0] limit;

	assign refill_inc = cur.refill_timer + 1'b1;
	assign limit = (int'(cfg.buffer_limit) > tbsq_pkg::QUEUE_DEPTH)
		? tbsq_pkg::CNT_W'(tbsq_pkg::QUEUE_DEPTH) : cfg.buffer_limit;

	always_comb begin
		logic [tbsq_pkg::TOK_W-1:0] tok;
		logic                       done;
		nxt            = cur;
		res.event_kind = tbsq_pkg::EV_NONE;
		res.event_tag  = '0;
		mem_wr.wr_en   = 1'b0;
		mem_wr.wr_addr = cur.tail;
		mem_wr.wr_data = packet_tag;
		tok            = cur.token_count;
		done           = 1'b0;
		if (operation == tbsq_pkg::OP_TICK) begin
			// refill first, then the service countdown
			if (refill_inc >= cfg.token_interval) begin
				nxt.refill_timer = '0;
				if (cur.token_count < cfg.token_max) begin
					tok = cur.token_count + 1'b1;
				end
			end else begin
				nxt.refill_timer = refill_inc;
			end
			if (cur.busy) begin
				done = (cur.service_timer <= tbsq_pkg::TMR_W'(1));
				nxt.service_timer = done ? '0 : cur.service_timer - 1'b1;
				if (done && (tok != '0)) begin
					tok            = tok - 1'b1;
					res.event_kind = tbsq_pkg::EV_DEPARTED;
					res.event_tag  = cur.serving_tag;
					if (cur.count != '0) begin
						nxt.serving_tag   = head_data;
						nxt.service_timer = cfg.service_time;
						nxt.head          = tbsq_pkg::ptr_next(cur.head);
						nxt.count         = cur.count - 1'b1;
					end else begin
						nxt.busy          = 1'b0;
						nxt.serving_tag   = '0;
						nxt.service_timer = '0;
					end
				end
			end
			nxt.token_count = tok;
		end else begin
			res.event_tag = packet_tag;
			priority if (cur.token_count == '0) begin
				res.event_kind = tbsq_pkg::EV_DROP_TOKEN;
			end else if (!cur.busy) begin
				nxt.busy          = 1'b1;
				nxt.serving_tag   = packet_tag;
				nxt.service_timer = cfg.service_time;
				res.event_kind    = tbsq_pkg::EV_STARTED;
			end else if (cur.count < limit) begin
				mem_wr.wr_en   = 1'b1;
				nxt.tail       = tbsq_pkg::ptr_next(cur.tail);
				nxt.count      = cur.count + 1'b1;
				res.event_kind = tbsq_pkg::EV_QUEUED;
			end else begin
				res.event_kind = tbsq_pkg::EV_DROP_FULL;
			end
		end
		res.queue_length = nxt.count;
		res.server_busy  = nxt.busy;
		res.tokens_left  = nxt.token_count;
	end

endmodule

@@ sv/token_bucket_shaper_queue_core.sv @@
// token_bucket_shaper_queue_core: token bucket shaper with one server and a waiting queue
// a result is registered in the update phase after its request is accepted, or later if held
// one request at a time: a new request is taken only in the idle phase, and the update phase
//   waits while the previous result is still held
// reset: asynchronous, clears control and shaper state and loads the register defaults,
//   token count starts at 8; the queue memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module token_bucket_shaper_queue_core (
	input  logic                            clk,
	input  logic                            arst_n,
	tbsq_item_if.sink                       items,
	tbsq_result_if.source                   results,
	input  logic                            wr_en,
	input  logic [tbsq_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tbsq_pkg::CFG_DATA_W-1:0] wr_data
);

	tbsq_pkg::tbsq_phase_t  phase_q;
	tbsq_pkg::tbsq_phase_t  phase_nxt;
	tbsq_pkg::tbsq_cfg_t    cfg_q;
	tbsq_pkg::tbsq_ctx_t    ctx_q;
	tbsq_pkg::tbsq_ctx_t    ctx_nxt;
	tbsq_pkg::tbsq_result_t res_nxt;
	tbsq_pkg::tbsq_result_t res_q;
	tbsq_pkg::tbsq_mem_wr_t mem_wr;
	logic                   out_valid_q;
	logic                   op_s1;
	logic [tbsq_pkg::TAG_BITS-1:0] tag_s1;
	logic [tbsq_pkg::TAG_BITS-1:0] head_rd_q;
	logic                   in_ready;
	logic                   exec_go;

	logic [tbsq_pkg::TAG_BITS-1:0] queue_mem [tbsq_pkg::QUEUE_DEPTH];

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			tbsq_pkg::PH_IDLE: begin
				if (items.valid) begin
					phase_nxt = tbsq_pkg::PH_EXEC;
				end
			end
			tbsq_pkg::PH_EXEC: begin
				if (exec_go) begin
					phase_nxt = tbsq_pkg::PH_IDLE;
				end
			end
			default: phase_nxt = tbsq_pkg::PH_IDLE;
		endcase
	end

	// phase outputs
	always_comb begin
		in_ready = 1'b0;
		exec_go  = 1'b0;
		unique case (phase_q)
			tbsq_pkg::PH_IDLE: in_ready = 1'b1;
			tbsq_pkg::PH_EXEC: exec_go = !out_valid_q || results.ready;
			default: in_ready = 1'b0;
		endcase
	end

	assign items.ready = in_ready;

	tbsq_step u_step (
		.cfg        (cfg_q),
		.cur        (ctx_q),
		.operation  (op_s1),
		.packet_tag (tag_s1),
		.head_data  (head_rd_q),
		.nxt        (ctx_nxt),
		.res        (res_nxt),
		.mem_wr     (mem_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tbsq_pkg::PH_IDLE;
			out_valid_q <= 1'b0;
			cfg_q.token_max      <= tbsq_pkg::TOKEN_MAX_RST;
			cfg_q.token_interval <= tbsq_pkg::TOKEN_INTERVAL_RST;
			cfg_q.service_time   <= tbsq_pkg::SERVICE_TIME_RST;
			cfg_q.buffer_limit   <= tbsq_pkg::BUFFER_LIMIT_RST;
			ctx_q.token_count   <= tbsq_pkg::TOKEN_MAX_RST;
			ctx_q.refill_timer  <= '0;
			ctx_q.service_timer <= '0;
			ctx_q.busy          <= 1'b0;
			ctx_q.serving_tag   <= '0;
			ctx_q.head          <= '0;
			ctx_q.tail          <= '0;
			ctx_q.count         <= '0;
		end else begin
			phase_q <= phase_nxt;
			if (exec_go) begin
				out_valid_q <= 1'b1;
				ctx_q       <= ctx_nxt;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				unique case (wr_index)
					tbsq_pkg::REG_TOKEN_MAX:
						cfg_q.token_max <= wr_data[tbsq_pkg::TOK_W-1:0];
					tbsq_pkg::REG_TOKEN_INTERVAL:
						cfg_q.token_interval <= wr_data[tbsq_pkg::TMR_W-1:0];
					tbsq_pkg::REG_SERVICE_TIME:
						cfg_q.service_time <= wr_data[tbsq_pkg::TMR_W-1:0];
					tbsq_pkg::REG_BUFFER_LIMIT:
						cfg_q.buffer_limit <= wr_data[tbsq_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (items.valid && in_ready) begin
			op_s1  <= items.operation;
			tag_s1 <= items.packet_tag;
		end
		if (exec_go) begin
			res_q <= res_nxt;
		end
	end

	// queue memory, head read registered every cycle
	always_ff @(posedge clk) begin
		if (exec_go && mem_wr.wr_en) begin
			queue_mem[mem_wr.wr_addr] <= mem_wr.wr_data;
		end
		head_rd_q <= queue_mem[ctx_q.head];
	end

	assign results.valid        = out_valid_q;
	assign results.event_kind   = res_q.event_kind;
	assign results.event_tag    = res_q.event_tag;
	assign results.queue_length = res_q.queue_length;
	assign results.server_busy  = res_q.server_busy;
	assign results.tokens_left  = res_q.tokens_left;

endmodule

@@ sv/tbsq_checker.sv @@
// tbsq_checker: port level assertions of the shaper, bound to the top level
`timescale 1ns / 1ps

module tbsq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tbsq_pkg::KIND_W-1:0]     event_kind,
	input logic [tbsq_pkg::TAG_BITS-1:0]   event_tag,
	input logic [tbsq_pkg::CNT_W-1:0]      queue_length,
	input logic                            server_busy
);

	// a held result keeps its event kind and tag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(event_tag))
		else $error("result changed while held");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// an idle server means an empty queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !server_busy |-> queue_length == '0)
		else $error("queue holds packets with the server idle");

	a_none_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == tbsq_pkg::EV_NONE |-> event_tag == '0)
		else $error("tag reported without an event");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == tbsq_pkg::EV_STARTED || event_kind == tbsq_pkg::EV_QUEUED)
		|-> server_busy)
		else $error("start or queue event with the server idle");

endmodule

bind token_bucket_shaper_queue_core tbsq_checker u_tbsq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.event_kind   (results.event_kind),
	.event_tag    (results.event_tag),
	.queue_length (results.queue_length),
	.server_busy  (results.server_busy)
);

@@ tb/token_bucket_shaper_queue_core_tb.sv @@
// testbench of the shaper core: random request and result gaps, predicted events checked in order
`timescale 1ns / 1ps

module token_bucket_shaper_queue_core_tb;
	import tbsq_pkg::*;

	class shaper_scoreboard;
		logic [TOK_W-1:0]    cap;
		logic [TMR_W-1:0]    refill_period;
		logic [TMR_W-1:0]    svc_period;
		logic [CNT_W-1:0]    wait_limit;
		logic [TOK_W-1:0]    tokens;
		logic [TMR_W-1:0]    refill_cnt;
		logic [TMR_W-1:0]    svc_cnt;
		logic                busy;
		logic [TAG_BITS-1:0] cur_tag;
		logic [TAG_BITS-1:0] waiting[$];
		tbsq_result_t        events_due[$];
		int                  errors;

		function new();
			cap = TOKEN_MAX_RST;
			refill_period = TOKEN_INTERVAL_RST;
			svc_period = SERVICE_TIME_RST;
			wait_limit = BUFFER_LIMIT_RST;
			tokens = TOKEN_MAX_RST;
			refill_cnt = '0;
			svc_cnt = '0;
			busy = 1'b0;
			cur_tag = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TOKEN_MAX:      cap = data[TOK_W-1:0];
				REG_TOKEN_INTERVAL: refill_period = data[TMR_W-1:0];
				REG_SERVICE_TIME:   svc_period = data[TMR_W-1:0];
				REG_BUFFER_LIMIT:   wait_limit = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return events_due.size();
		endfunction

		// work out the event of one accepted request
		function void note_request(logic op, logic [TAG_BITS-1:0] tag);
			tbsq_result_t ev;
			int lim;
			logic done;
			ev = '0;
			if (op == OP_TICK) begin
				refill_cnt = refill_cnt + 1'b1;
				if (refill_cnt >= refill_period) begin
					refill_cnt = '0;
					if (tokens < cap)
						tokens = tokens + 1'b1;
				end
				if (busy) begin
					if (svc_cnt > 1) begin
						svc_cnt = svc_cnt - 1'b1;
						done = 1'b0;
					end else begin
						svc_cnt = '0;
						done = 1'b1;
					end
					if (done && tokens > 0) begin
						tokens = tokens - 1'b1;
						ev.event_kind = EV_DEPARTED;
						ev.event_tag = cur_tag;
						if (waiting.size() > 0) begin
							cur_tag = waiting.pop_front();
							svc_cnt = svc_period;
						end else begin
							busy = 1'b0;
							cur_tag = '0;
							svc_cnt = '0;
						end
					end
				end
			end else begin
				lim = (wait_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(wait_limit);
				ev.event_tag = tag;
				if (tokens == 0) begin
					ev.event_kind = EV_DROP_TOKEN;
				end else if (!busy) begin
					busy = 1'b1;
					cur_tag = tag;
					svc_cnt = svc_period;
					ev.event_kind = EV_STARTED;
				end else if (waiting.size() < lim) begin
					waiting.push_back(tag);
					ev.event_kind = EV_QUEUED;
				end else begin
					ev.event_kind = EV_DROP_FULL;
				end
			end
			ev.queue_length = CNT_W'(waiting.size());
			ev.server_busy = busy;
			ev.tokens_left = tokens;
			events_due.push_back(ev);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t ns: %s", $time, msg);
		endtask

		task check_result(tbsq_result_t got);
			tbsq_result_t want;
			if (events_due.size() == 0) begin
				report($sformatf("result with none expected: kind %0d tag %h",
					got.event_kind, got.event_tag));
				return;
			end
			want = events_due.pop_front();
			if (got.event_kind !== want.event_kind)
				report($sformatf("event_kind %0d, expected %0d", got.event_kind, want.event_kind));
			if (got.event_tag !== want.event_tag)
				report($sformatf("event_tag %h, expected %h", got.event_tag, want.event_tag));
			if (got.queue_length !== want.queue_length)
				report($sformatf("queue_length %0d, expected %0d",
					got.queue_length, want.queue_length));
			if (got.server_busy !== want.server_busy)
				report($sformatf("server_busy %b, expected %b", got.server_busy, want.server_busy));
			if (got.tokens_left !== want.tokens_left)
				report($sformatf("tokens_left %0d, expected %0d", got.tokens_left, want.tokens_left));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  gapless;

	tbsq_item_if   item_ch();
	tbsq_result_if result_ch();

	shaper_scoreboard sb;

	token_bucket_shaper_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (item_ch),
		.results  (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [TAG_BITS-1:0] corner_tag(int i);
		logic [TAG_BITS-1:0] t;
		case (i % 8)
			0: t = 16'hFFFF;
			1: t = 16'h0000;
			2: t = 16'hAAAA;
			3: t = 16'h5555;
			4: t = 16'h8000;
			5: t = 16'h0001;
			6: t = 16'h7FFF;
			default: t = 16'hFFFE;
		endcase
		return t;
	endfunction

	task automatic send_request(input logic op, input logic [TAG_BITS-1:0] tag);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.packet_tag <= tag;
		do @(posedge clk); while (!(item_ch.valid === 1'b1 && item_ch.ready === 1'b1));
		sb.note_request(op, tag);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int p);
		logic [CFG_DATA_W-1:0] tmax, period, svc, lim;
		int n, pct, i;
		logic op;
		logic [TAG_BITS-1:0] tag;
		case (p)
			0: begin
				// upper bits beyond each register are dropped
				tmax = 32'hFFFF_0001; period = 3; svc = 1; lim = 32'h0000_0081; n = 25; pct = 60;
			end
			1: begin tmax = 8; period = 100; svc = 10; lim = 64; n = 125; pct = 55; end
			2: begin tmax = 65535; period = 1; svc = 1; lim = 0; n = 90; pct = 50; end
			3: begin tmax = 4; period = 1000; svc = 2; lim = 5; n = 80; pct = 40; end
			4: begin tmax = 2; period = 2; svc = 3; lim = 3; n = 90; pct = 45; end
			5: begin tmax = 3; period = 0; svc = 0; lim = 2; n = 80; pct = 50; end
			6: begin tmax = 0; period = 5; svc = 4; lim = 127; n = 80; pct = 60; end
			7, 8: begin
				tmax = $urandom_range(1, 6);
				period = $urandom_range(1, 12);
				svc = $urandom_range(1, 8);
				lim = $urandom_range(0, 8);
				n = 100;
				pct = 50;
			end
			9: begin tmax = 65535; period = 1; svc = 1; lim = 64; n = 80; pct = 50; end
			default: begin
				// server never finishes, queue fills to the top
				tmax = 1; period = 32'hFFFF_FFFF; svc = 32'hFFFF_FFFF; lim = 64; n = 100; pct = 80;
			end
		endcase
		wait_drained();
		write_reg(REG_TOKEN_MAX, tmax);
		write_reg(REG_TOKEN_INTERVAL, period);
		write_reg(REG_SERVICE_TIME, svc);
		write_reg(REG_BUFFER_LIMIT, lim);
		wr_en <= 1'b0;
		for (i = 0; i < n; i++) begin
			if (i % 20 == 0)
				gapless = (p == 2) || ($urandom_range(0, 3) == 0);
			if (p == 0) begin
				op = (i % 5 < 3) ? OP_ARRIVAL : OP_TICK;
				tag = corner_tag(i);
			end else begin
				op = ($urandom_range(0, 99) < pct) ? OP_ARRIVAL : OP_TICK;
				if ($urandom_range(0, 9) == 0)
					tag = corner_tag($urandom_range(0, 7));
				else
					tag = TAG_BITS'($urandom_range(0, 16'hFFFF));
			end
			send_request(op, tag);
		end
		item_ch.valid <= 1'b0;
	endtask

	// result side with random stalls
	initial begin
		tbsq_result_t got;
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = gapless ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
			got.event_kind = result_ch.event_kind;
			got.event_tag = result_ch.event_tag;
			got.queue_length = result_ch.queue_length;
			got.server_busy = result_ch.server_busy;
			got.tokens_left = result_ch.tokens_left;
			sb.check_result(got);
		end
	end

	initial begin
		int p;
		sb = new();
		gapless = 1'b0;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OP_TICK;
		item_ch.packet_tag <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p <= 10; p++)
			run_phase(p);
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/tbsq_pkg.sv
sv/tbsq_if.sv
sv/tbsq_step.sv
sv/token_bucket_shaper_queue_core.sv
sv/tbsq_checker.sv
tb/token_bucket_shaper_queue_core_tb.sv
